// ----- rtl/core/csfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csfe_pkg
// Shared types, codes and calendar helpers for the clock set field editor.
// ----------------------------------------------------------------------------
package csfe_pkg;

  // Encoder event codes
  typedef enum logic [1:0] {
    ActInc    = 2'd0,
    ActDec    = 2'd1,
    ActNext   = 2'd2,
    ActToggle = 2'd3
  } action_e;

  // Cursor codes, one per editable field
  typedef enum logic [2:0] {
    FieldYear   = 3'd0,
    FieldMonth  = 3'd1,
    FieldDate   = 3'd2,
    FieldHour   = 3'd3,
    FieldMinute = 3'd4,
    FieldSecond = 3'd5
  } field_e;

  // Field limits
  localparam logic [6:0] YearMax   = 7'd99;
  localparam logic [3:0] MonthMax  = 4'd12;
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinSecMax = 6'd59;

  // Held date and time under edit
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } edit_t;

  // Days in month for 20yy; an invalid month counts as 31 days
  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic [6:0] year);
    logic [4:0] days;
    case (month) inside
      4'd2:                     days = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  days = 5'd30;
      default:                  days = 5'd31;
    endcase
    return days;
  endfunction

  // One wrapping step of a field between lo and hi
  function automatic logic [6:0] field_step(input logic [6:0] v,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi,
                                            input logic       up);
    logic [6:0] r;
    if (up) begin
      r = (v < hi) ? v + 7'd1 : lo;
    end else begin
      r = (v > lo) ? v - 7'd1 : hi;
    end
    return r;
  endfunction

  // Clamp all fields in order, so the date follows the clamped month and year
  function automatic edit_t clamp_time(input edit_t t);
    edit_t      r;
    logic [4:0] dim;
    r = t;
    if (r.year > YearMax) r.year = YearMax;
    if (r.month > MonthMax) begin
      r.month = MonthMax;
    end else if (r.month == 4'd0) begin
      r.month = 4'd1;
    end
    dim = days_in_month(r.month, r.year);
    if (r.date > dim) begin
      r.date = dim;
    end else if (r.date == 5'd0) begin
      r.date = 5'd1;
    end
    if (r.hour > HourMax) r.hour = HourMax;
    if (r.minute > MinSecMax) r.minute = MinSecMax;
    if (r.second > MinSecMax) r.second = MinSecMax;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clock_set_field_editor_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clock_set_field_editor_top
// Encoder-driven date and time editor with a valid/stall item interface.
// ----------------------------------------------------------------------------
// Each encoder event is one input item and gives exactly one result item in the
// next cycle. The edit state registers are also the result register, so an
// item is taken in every cycle while the output side keeps up; in_stall_o is
// raised only while a finished result waits on a stalled output. The update
// is one pass of logic: a wrapping step of the selected field followed by a
// clamp of all six fields, where the day-of-month limit of the clamped month
// and year sets the longest path.
// ----------------------------------------------------------------------------
module clock_set_field_editor_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input items
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [6:0] rtc_year_i,
  input  wire logic [3:0] rtc_month_i,
  input  wire logic [4:0] rtc_date_i,
  input  wire logic [4:0] rtc_hour_i,
  input  wire logic [5:0] rtc_minute_i,
  input  wire logic [5:0] rtc_second_i,
  // result items
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            editing_o,
  output logic [2:0]      cursor_o,
  output logic [6:0]      out_year_o,
  output logic [3:0]      out_month_o,
  output logic [4:0]      out_date_o,
  output logic [4:0]      out_hour_o,
  output logic [5:0]      out_minute_o,
  output logic [5:0]      out_second_o,
  output logic            commit_o
);

  logic                 in_accept;
  logic                 out_valid_q;
  logic                 active_q, active_d;
  csfe_pkg::field_e     cursor_q, cursor_d;
  csfe_pkg::edit_t      ed_q, ed_d;
  logic                 commit_q, commit_d;
  csfe_pkg::action_e    action;
  csfe_pkg::field_e     idx;
  csfe_pkg::edit_t      turned;
  logic [6:0]           cur_v, lo_v, hi_v, new_v;

  // Stall only while a result waits on a stalled output
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign action     = csfe_pkg::action_e'(action_i);

  // Saturate the cursor onto the second field for unused codes
  assign idx = (cursor_q > csfe_pkg::FieldSecond) ? csfe_pkg::FieldSecond : cursor_q;

  // Select the field under the cursor and its limits
  always_comb begin
    unique case (idx)
      csfe_pkg::FieldYear: begin
        cur_v = ed_q.year;
        lo_v  = 7'd0;
        hi_v  = csfe_pkg::YearMax;
      end
      csfe_pkg::FieldMonth: begin
        cur_v = {3'd0, ed_q.month};
        lo_v  = 7'd1;
        hi_v  = {3'd0, csfe_pkg::MonthMax};
      end
      csfe_pkg::FieldDate: begin
        cur_v = {2'd0, ed_q.date};
        lo_v  = 7'd1;
        hi_v  = {2'd0, csfe_pkg::days_in_month(ed_q.month, ed_q.year)};
      end
      csfe_pkg::FieldHour: begin
        cur_v = {2'd0, ed_q.hour};
        lo_v  = 7'd0;
        hi_v  = {2'd0, csfe_pkg::HourMax};
      end
      csfe_pkg::FieldMinute: begin
        cur_v = {1'b0, ed_q.minute};
        lo_v  = 7'd0;
        hi_v  = {1'b0, csfe_pkg::MinSecMax};
      end
      default: begin
        cur_v = {1'b0, ed_q.second};
        lo_v  = 7'd0;
        hi_v  = {1'b0, csfe_pkg::MinSecMax};
      end
    endcase
  end

  // Step the selected field and write it back
  always_comb begin
    new_v  = csfe_pkg::field_step(cur_v, lo_v, hi_v, action == csfe_pkg::ActInc);
    turned = ed_q;
    unique case (idx)
      csfe_pkg::FieldYear:   turned.year   = new_v;
      csfe_pkg::FieldMonth:  turned.month  = new_v[3:0];
      csfe_pkg::FieldDate:   turned.date   = new_v[4:0];
      csfe_pkg::FieldHour:   turned.hour   = new_v[4:0];
      csfe_pkg::FieldMinute: turned.minute = new_v[5:0];
      default:               turned.second = new_v[5:0];
    endcase
  end

  // Next edit state for one item
  always_comb begin
    active_d = active_q;
    cursor_d = cursor_q;
    ed_d     = ed_q;
    commit_d = 1'b0;
    unique case (action)
      csfe_pkg::ActToggle: begin
        if (active_q) begin
          active_d = 1'b0;
          commit_d = 1'b1;
        end else begin
          active_d = 1'b1;
          cursor_d = csfe_pkg::FieldYear;
          ed_d     = '{year:   rtc_year_i,   month:  rtc_month_i,
                       date:   rtc_date_i,   hour:   rtc_hour_i,
                       minute: rtc_minute_i, second: rtc_second_i};
        end
      end
      csfe_pkg::ActNext: begin
        if (active_q) begin
          cursor_d = (cursor_q < csfe_pkg::FieldSecond)
                   ? csfe_pkg::field_e'(cursor_q + 3'd1) : csfe_pkg::FieldYear;
        end
      end
      default: begin
        if (active_q) begin
          ed_d = csfe_pkg::clamp_time(turned);
        end
      end
    endcase
  end

  // Advance edit state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cursor_q <= csfe_pkg::FieldYear;
      ed_q     <= '{year: 7'd0, month: 4'd1, date: 5'd1,
                    hour: 5'd0, minute: 6'd0, second: 6'd0};
      commit_q <= 1'b0;
    end else if (in_accept) begin
      active_q <= active_d;
      cursor_q <= cursor_d;
      ed_q     <= ed_d;
      commit_q <= commit_d;
    end
  end

  // Hold result valid until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Drive result ports from the state registers
  assign out_valid_o  = out_valid_q;
  assign editing_o    = active_q;
  assign cursor_o     = cursor_q;
  assign out_year_o   = ed_q.year;
  assign out_month_o  = ed_q.month;
  assign out_date_o   = ed_q.date;
  assign out_hour_o   = ed_q.hour;
  assign out_minute_o = ed_q.minute;
  assign out_second_o = ed_q.second;
  assign commit_o     = commit_q;

  // Checks
  a_commit_leaves_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && commit_o |-> !editing_o)
    else $error("commit raised while still editing");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= csfe_pkg::FieldSecond)
    else $error("cursor left the field range");

  a_enter_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && action == csfe_pkg::ActToggle && !active_q
    |=> active_q && cursor_q == csfe_pkg::FieldYear && !commit_q)
    else $error("entering edit mode did not reset the cursor");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule
`default_nettype wire
